/* design/gnss_nmea_ubx_deframer_assert.svh */
// assertion macros for the gnss nmea/ubx deframer
`ifndef GNSS_NMEA_UBX_DEFRAMER_ASSERT_SVH
`define GNSS_NMEA_UBX_DEFRAMER_ASSERT_SVH

`ifndef ASSERT_OFF
`define GND_ASSERT(label, clock, reset, prop) \
  label: assert property (@(posedge clock) disable iff (reset) prop) \
    else $error("deframer assertion failed");
`define GND_ASSERT_NEVER(label, clock, reset, cond) \
  label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
    else $error("deframer forbidden condition seen");
`else
`define GND_ASSERT(label, clock, reset, prop)
`define GND_ASSERT_NEVER(label, clock, reset, cond)
`endif

`endif

/* design/gnssdf_pkg.sv */
// shared types and constants for the gnss nmea/ubx deframer
package gnssdf_pkg;

  localparam int SENTENCE_CAPACITY_DEF = 128;
  localparam int OUT_DEPTH = 4;

  localparam logic [15:0] PVT_LEN_RESET = 16'd92;
  localparam logic [15:0] HP_LEN_RESET  = 16'd36;

  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PVT_LEN = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_HP_LEN  = 1'b1;

  typedef enum logic [1:0] {
    EV_NMEA_GOOD = 2'd0,
    EV_NMEA_BAD  = 2'd1,
    EV_UBX_GOOD  = 2'd2
  } event_kind_t;

  localparam logic [1:0] SC_OTHER = 2'd0;
  localparam logic [1:0] SC_GGA   = 2'd1;
  localparam logic [1:0] SC_RMC   = 2'd2;

  localparam logic [7:0] UBX_SYNC_A   = 8'hB5;
  localparam logic [7:0] UBX_SYNC_B   = 8'h62;
  localparam logic [7:0] CLASS_NAV    = 8'h01;
  localparam logic [7:0] ID_PVT       = 8'h07;
  localparam logic [7:0] ID_HPPOS     = 8'h14;
  localparam logic [7:0] ID_DOP       = 8'h04;
  localparam logic [7:0] ID_SAT       = 8'h35;
  localparam logic [15:0] DOP_LEN     = 16'd18;
  localparam logic [15:0] SAT_HEAD_LEN = 16'd8;
  localparam logic [3:0] SAT_REC_LAST  = 4'd11;
  localparam logic [3:0] SAT_SIG_POS   = 4'd2;
  localparam logic [3:0] SAT_FLAG_POS  = 4'd8;
  localparam logic [7:0] SAT_USED_MASK = 8'h08;

  typedef struct packed {
    logic [15:0] pvt_len;
    logic [15:0] hp_len;
  } cfg_t;

  typedef struct packed {
    logic [31:0] ubx_good_total;
    logic [31:0] nmea_bad_total;
    logic [31:0] nmea_good_total;
    logic [7:0]  used_satellites;
    logic [7:0]  best_signal;
    logic [15:0] payload_length;
    logic [7:0]  frame_id;
    logic [1:0]  sentence_code;
    event_kind_t event_kind;
  } result_t;

endpackage

/* design/gnssdf_parser.sv */
// byte parser: nmea/ubx framing state, checksums and event generation
module gnssdf_parser #(
  parameter int SentenceCapacity = gnssdf_pkg::SENTENCE_CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  gnssdf_pkg::cfg_t   cfg,
  input  logic               byte_valid,
  input  logic [7:0]         rx_byte,
  output logic               res_valid,
  output gnssdf_pkg::result_t res
);

  localparam int CountW = $clog2(SentenceCapacity + 1);
  localparam logic [CountW-1:0] CountMax = CountW'(SentenceCapacity);

  typedef enum logic [3:0] {
    PH_IDLE, PH_NMEA_TYPE, PH_NMEA_DATA, PH_NMEA_CK1, PH_NMEA_CK2,
    PH_UBX_SYNC2, PH_UBX_CLASS, PH_UBX_ID, PH_UBX_LEN1, PH_UBX_LEN2,
    PH_UBX_PAYLOAD, PH_UBX_CKA, PH_UBX_CKB
  } phase_t;

  function automatic logic [7:0] hex_digit(input logic [7:0] b);
    if (b >= 8'h41) begin
      return b - 8'h41 + 8'd10;
    end
    return b - 8'h30;
  endfunction

  phase_t phase, phase_next;
  logic [7:0] xor_sum, xor_sum_next;
  logic [CountW-1:0] body_count, body_count_next;
  logic [7:0] head_chars [5];
  logic [7:0] head_chars_next [5];
  logic [7:0] given_high, given_high_next;
  logic [7:0] msg_class, msg_class_next;
  logic [7:0] msg_id, msg_id_next;
  logic [15:0] msg_length, msg_length_next;
  logic [15:0] payload_index, payload_index_next;
  logic [7:0] sum_a, sum_a_next;
  logic [7:0] sum_b, sum_b_next;
  logic [3:0] record_pos, record_pos_next;
  logic [7:0] max_signal, max_signal_next;
  logic [7:0] used_count, used_count_next;
  logic [31:0] good_nmea, good_nmea_next;
  logic [31:0] bad_nmea, bad_nmea_next;
  logic [31:0] good_ubx, good_ubx_next;

  logic [7:0] fl_a, fl_b;
  logic [7:0] rx_digit;
  logic [8:0] given_sum;
  logic [15:0] full_length;
  logic       header_ok;
  logic [1:0] sentence_code;
  logic [15:0] index_inc;

  assign fl_a        = sum_a + rx_byte;
  assign fl_b        = sum_b + fl_a;
  assign rx_digit    = hex_digit(rx_byte);
  assign given_sum   = {1'b0, given_high} + {1'b0, rx_digit};
  assign full_length = {rx_byte, msg_length[7:0]};
  assign index_inc   = payload_index + 16'd1;

  always_comb begin
    header_ok = 1'b0;
    if (msg_class == gnssdf_pkg::CLASS_NAV) begin
      case (msg_id)
        gnssdf_pkg::ID_PVT:   header_ok = (full_length == cfg.pvt_len);
        gnssdf_pkg::ID_HPPOS: header_ok = (full_length == cfg.hp_len);
        gnssdf_pkg::ID_DOP:   header_ok = (full_length == gnssdf_pkg::DOP_LEN);
        gnssdf_pkg::ID_SAT:   header_ok = 1'b1;
        default:              header_ok = 1'b0;
      endcase
    end
  end

  // talker G[PNABL] followed by GGA or RMC
  always_comb begin
    logic talker_ok;
    talker_ok = (head_chars[1] == "P") || (head_chars[1] == "N") ||
                (head_chars[1] == "A") || (head_chars[1] == "B") ||
                (head_chars[1] == "L");
    sentence_code = gnssdf_pkg::SC_OTHER;
    if (body_count >= CountW'(5) && head_chars[0] == "G" && talker_ok) begin
      if (head_chars[2] == "G" && head_chars[3] == "G" && head_chars[4] == "A") begin
        sentence_code = gnssdf_pkg::SC_GGA;
      end else if (head_chars[2] == "R" && head_chars[3] == "M" &&
                   head_chars[4] == "C") begin
        sentence_code = gnssdf_pkg::SC_RMC;
      end
    end
  end

  always_comb begin
    phase_next         = phase;
    xor_sum_next       = xor_sum;
    body_count_next    = body_count;
    head_chars_next    = head_chars;
    given_high_next    = given_high;
    msg_class_next     = msg_class;
    msg_id_next        = msg_id;
    msg_length_next    = msg_length;
    payload_index_next = payload_index;
    sum_a_next         = sum_a;
    sum_b_next         = sum_b;
    record_pos_next    = record_pos;
    max_signal_next    = max_signal;
    used_count_next    = used_count;
    good_nmea_next     = good_nmea;
    bad_nmea_next      = bad_nmea;
    good_ubx_next      = good_ubx;
    res_valid          = 1'b0;
    res                = '0;

    if (byte_valid) begin
      unique case (phase)
        PH_IDLE: begin
          if (rx_byte == "$") begin
            xor_sum_next    = '0;
            body_count_next = '0;
            phase_next      = PH_NMEA_TYPE;
          end else if (rx_byte == gnssdf_pkg::UBX_SYNC_A) begin
            phase_next = PH_UBX_SYNC2;
          end
        end
        PH_NMEA_TYPE, PH_NMEA_DATA: begin
          if (rx_byte == "$") begin
            xor_sum_next    = '0;
            body_count_next = '0;
            phase_next      = PH_NMEA_TYPE;
          end else if (rx_byte == "*") begin
            phase_next = PH_NMEA_CK1;
          end else begin
            xor_sum_next = xor_sum ^ rx_byte;
            if (body_count < CountMax) begin
              for (int i = 0; i < 5; i++) begin
                if (body_count == CountW'(i)) begin
                  head_chars_next[i] = rx_byte;
                end
              end
              body_count_next = body_count + CountW'(1);
            end
            if (rx_byte == ",") begin
              phase_next = PH_NMEA_DATA;
            end
          end
        end
        PH_NMEA_CK1: begin
          given_high_next = {rx_digit[3:0], 4'b0000};
          phase_next      = PH_NMEA_CK2;
        end
        PH_NMEA_CK2: begin
          res_valid = 1'b1;
          if (given_sum == {1'b0, xor_sum}) begin
            good_nmea_next    = good_nmea + 32'd1;
            res.event_kind    = gnssdf_pkg::EV_NMEA_GOOD;
            res.sentence_code = sentence_code;
          end else begin
            bad_nmea_next  = bad_nmea + 32'd1;
            res.event_kind = gnssdf_pkg::EV_NMEA_BAD;
          end
          res.nmea_good_total = good_nmea_next;
          res.nmea_bad_total  = bad_nmea_next;
          res.ubx_good_total  = good_ubx;
          phase_next          = PH_IDLE;
        end
        PH_UBX_SYNC2: begin
          phase_next = (rx_byte == gnssdf_pkg::UBX_SYNC_B) ? PH_UBX_CLASS : PH_IDLE;
        end
        PH_UBX_CLASS: begin
          msg_class_next = rx_byte;
          sum_a_next     = rx_byte;
          sum_b_next     = rx_byte;
          phase_next     = PH_UBX_ID;
        end
        PH_UBX_ID: begin
          msg_id_next = rx_byte;
          sum_a_next  = fl_a;
          sum_b_next  = fl_b;
          phase_next  = PH_UBX_LEN1;
        end
        PH_UBX_LEN1: begin
          msg_length_next = {8'h00, rx_byte};
          sum_a_next      = fl_a;
          sum_b_next      = fl_b;
          phase_next      = PH_UBX_LEN2;
        end
        PH_UBX_LEN2: begin
          msg_length_next    = full_length;
          sum_a_next         = fl_a;
          sum_b_next         = fl_b;
          payload_index_next = '0;
          record_pos_next    = '0;
          if (!header_ok) begin
            phase_next = PH_IDLE;
          end else begin
            if (msg_id == gnssdf_pkg::ID_SAT) begin
              max_signal_next = '0;
              used_count_next = '0;
            end
            phase_next = (full_length != 16'd0) ? PH_UBX_PAYLOAD : PH_UBX_CKA;
          end
        end
        PH_UBX_PAYLOAD: begin
          sum_a_next = fl_a;
          sum_b_next = fl_b;
          // satellite records start after the 8-byte header, 12 bytes each
          if (msg_class == gnssdf_pkg::CLASS_NAV && msg_id == gnssdf_pkg::ID_SAT &&
              payload_index >= gnssdf_pkg::SAT_HEAD_LEN) begin
            if (record_pos == gnssdf_pkg::SAT_SIG_POS) begin
              if (rx_byte > max_signal) begin
                max_signal_next = rx_byte;
              end
            end else if (record_pos == gnssdf_pkg::SAT_FLAG_POS) begin
              if ((rx_byte & gnssdf_pkg::SAT_USED_MASK) != 8'h00 &&
                  used_count != 8'hFF) begin
                used_count_next = used_count + 8'd1;
              end
            end
            record_pos_next = (record_pos >= gnssdf_pkg::SAT_REC_LAST) ?
                              4'd0 : record_pos + 4'd1;
          end
          payload_index_next = index_inc;
          if (index_inc >= msg_length) begin
            phase_next = PH_UBX_CKA;
          end
        end
        PH_UBX_CKA: begin
          phase_next = (rx_byte == sum_a) ? PH_UBX_CKB : PH_IDLE;
        end
        PH_UBX_CKB: begin
          phase_next = PH_IDLE;
          if (rx_byte == sum_b) begin
            good_ubx_next       = good_ubx + 32'd1;
            res_valid           = 1'b1;
            res.event_kind      = gnssdf_pkg::EV_UBX_GOOD;
            res.frame_id        = msg_id;
            res.payload_length  = msg_length;
            if (msg_id == gnssdf_pkg::ID_SAT) begin
              res.best_signal     = max_signal;
              res.used_satellites = used_count;
            end
            res.nmea_good_total = good_nmea;
            res.nmea_bad_total  = bad_nmea;
            res.ubx_good_total  = good_ubx_next;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      xor_sum       <= '0;
      body_count    <= '0;
      for (int i = 0; i < 5; i++) begin
        head_chars[i] <= '0;
      end
      given_high    <= '0;
      msg_class     <= '0;
      msg_id        <= '0;
      msg_length    <= '0;
      payload_index <= '0;
      sum_a         <= '0;
      sum_b         <= '0;
      record_pos    <= '0;
      max_signal    <= '0;
      used_count    <= '0;
      good_nmea     <= '0;
      bad_nmea      <= '0;
      good_ubx      <= '0;
    end else begin
      phase         <= phase_next;
      xor_sum       <= xor_sum_next;
      body_count    <= body_count_next;
      head_chars    <= head_chars_next;
      given_high    <= given_high_next;
      msg_class     <= msg_class_next;
      msg_id        <= msg_id_next;
      msg_length    <= msg_length_next;
      payload_index <= payload_index_next;
      sum_a         <= sum_a_next;
      sum_b         <= sum_b_next;
      record_pos    <= record_pos_next;
      max_signal    <= max_signal_next;
      used_count    <= used_count_next;
      good_nmea     <= good_nmea_next;
      bad_nmea      <= bad_nmea_next;
      good_ubx      <= good_ubx_next;
    end
  end

endmodule

/* design/gnssdf_out_fifo.sv */
// small result queue in front of the output stream
module gnssdf_out_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  gnssdf_pkg::result_t push_data,
  output logic [$clog2(gnssdf_pkg::OUT_DEPTH+1)-1:0] level,
  output logic                out_valid,
  input  logic                out_ready,
  output gnssdf_pkg::result_t out_data
);

  localparam int PtrW = $clog2(gnssdf_pkg::OUT_DEPTH);
  localparam int LevelW = $clog2(gnssdf_pkg::OUT_DEPTH + 1);

  gnssdf_pkg::result_t entries [gnssdf_pkg::OUT_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic            pop;

  assign out_valid = (level != '0);
  assign out_data  = entries[rd_ptr];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PtrW'(1);
      end
      level <= level + LevelW'(push) - LevelW'(pop);
    end
  end

endmodule

/* design/gnss_nmea_ubx_deframer.sv */
// top level of the gnss nmea/ubx deframer
//
//   channel  dir  handshake          payload
//   s_       in   s_tvalid/s_tready  s_tdata[7:0] rx_byte
//   m_       out  m_tvalid/m_tready  m_tuser event_kind, m_tdata result fields
//   cfg_     in   cfg_we             cfg_index, cfg_data
//
// one byte per clock while s_tready is high; a result reaches m_ once it is queued
// the byte register feeds the parser, whose result goes into a 4-entry queue
// s_tready falls only when the queue plus the byte in flight would fill it
// rst is synchronous and clears all control state and counters
module gnss_nmea_ubx_deframer #(
  parameter int SentenceCapacity = gnssdf_pkg::SENTENCE_CAPACITY_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] rx_byte
  output logic         m_tvalid,
  input  logic         m_tready,
  // [1:0] sentence_code, [9:2] frame_id, [25:10] payload_length,
  // [33:26] best_signal, [41:34] used_satellites, [73:42] nmea_good_total,
  // [105:74] nmea_bad_total, [137:106] ubx_good_total, [143:138] zero
  output logic [143:0] m_tdata,
  output logic [1:0]   m_tuser,   // [1:0] event_kind
  input  logic         cfg_we,
  input  logic [gnssdf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [15:0]  cfg_data
);

  localparam int LevelW = $clog2(gnssdf_pkg::OUT_DEPTH + 1);

  gnssdf_pkg::cfg_t    cfg;
  gnssdf_pkg::result_t res;
  gnssdf_pkg::result_t head;
  logic                res_valid;
  logic                in_valid;
  logic [7:0]          in_byte;
  logic [LevelW-1:0]   level;
  logic                out_pop;
  logic                queue_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pvt_len <= gnssdf_pkg::PVT_LEN_RESET;
      cfg.hp_len  <= gnssdf_pkg::HP_LEN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gnssdf_pkg::CFG_PVT_LEN: cfg.pvt_len <= cfg_data;
        gnssdf_pkg::CFG_HP_LEN:  cfg.hp_len  <= cfg_data;
        default: ;
      endcase
    end
  end

  // room for the byte in flight and the one being offered
  assign s_tready = ((level + LevelW'(in_valid)) < LevelW'(gnssdf_pkg::OUT_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= s_tvalid && s_tready;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  gnssdf_parser #(
    .SentenceCapacity(SentenceCapacity)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .byte_valid (in_valid),
    .rx_byte    (in_byte),
    .res_valid  (res_valid),
    .res        (res)
  );

  gnssdf_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .level     (level),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (head)
  );

  assign m_tuser = head.event_kind;
  assign m_tdata = {6'b000000, head.ubx_good_total, head.nmea_bad_total,
                    head.nmea_good_total, head.used_satellites, head.best_signal,
                    head.payload_length, head.frame_id, head.sentence_code};

  assign out_pop    = m_tvalid && m_tready;
  assign queue_full = (level == LevelW'(gnssdf_pkg::OUT_DEPTH));

`include "gnss_nmea_ubx_deframer_assert.svh"

  `GND_ASSERT_NEVER(a_no_overflow, clk, rst, res_valid && !out_pop && queue_full)
  `GND_ASSERT(a_pop_drains, clk, rst, (out_pop && !res_valid) |=> level == $past(level) - 3'd1)
  `GND_ASSERT(a_kind_legal, clk, rst, m_tvalid |-> (m_tuser <= 2'(gnssdf_pkg::EV_UBX_GOOD)))

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// self-checking testbench for the gnss nmea/ubx deframer
module tb;
  import gnssdf_pkg::*;

  typedef enum logic [3:0] {
    PS_IDLE, PS_NMEA_TYPE, PS_NMEA_DATA, PS_NMEA_CK1, PS_NMEA_CK2,
    PS_UBX_SYNC2, PS_UBX_CLASS, PS_UBX_ID, PS_UBX_LEN1, PS_UBX_LEN2,
    PS_UBX_PAYLOAD, PS_UBX_CKA, PS_UBX_CKB
  } parse_state_t;

  typedef enum int {
    CK_GOOD, CK_LOWER, CK_RANDOM, CK_BAD_FIRST, CK_BAD_SECOND
  } ck_mode_t;

  typedef logic [7:0] byte_q_t[$];

  localparam int WATCHDOG_CYCLES = 5000;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [143:0] m_tdata;
  logic [1:0] m_tuser;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_PVT_LEN;
  logic [15:0] cfg_data = '0;

  always #5 clk = ~clk;

  gnss_nmea_ubx_deframer i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // deframer state as the testbench sees it
  logic [15:0] pvt_len_q = PVT_LEN_RESET;
  logic [15:0] hp_len_q = HP_LEN_RESET;
  parse_state_t state_q = PS_IDLE;
  logic [7:0] sent_xor = '0;
  int unsigned body_len = 0;
  logic [7:0] head_q [5] = '{default: 8'h00};
  logic [7:0] ck_high = '0;
  logic [7:0] ubx_class = '0;
  logic [7:0] ubx_id = '0;
  logic [15:0] ubx_len = '0;
  logic [15:0] pay_idx = '0;
  logic [7:0] fl_a = '0;
  logic [7:0] fl_b = '0;
  logic [3:0] rec_pos = '0;
  logic [7:0] sig_max = '0;
  logic [7:0] sat_used = '0;
  logic [31:0] nmea_ok_cnt = '0;
  logic [31:0] nmea_bad_cnt = '0;
  logic [31:0] ubx_ok_cnt = '0;

  result_t expected_events[$];
  int errors = 0;
  bit src_gaps = 1'b1;
  bit sink_stalls = 1'b1;
  int unsigned bytes_sent = 0;
  int unsigned quiet_cycles = 0;

  function automatic logic [7:0] hex_value(logic [7:0] c);
    if (c >= 8'h41) return c - 8'h41 + 8'd10;
    return c - 8'h30;
  endfunction

  function automatic logic [1:0] sentence_kind();
    if (body_len < 5 || head_q[0] != "G") return SC_OTHER;
    if (!(head_q[1] inside {"P", "N", "A", "B", "L"})) return SC_OTHER;
    if ({head_q[2], head_q[3], head_q[4]} == "GGA") return SC_GGA;
    if ({head_q[2], head_q[3], head_q[4]} == "RMC") return SC_RMC;
    return SC_OTHER;
  endfunction

  // advance the deframer state by one byte, queue the event it gives if any
  task automatic parse_byte(input logic [7:0] b);
    result_t ev;
    logic [8:0] given;
    bit emit;
    bit hdr_ok;
    ev = '0;
    emit = 1'b0;
    case (state_q)
      PS_IDLE: begin
        if (b == CH_DOLLAR) begin
          sent_xor = '0;
          body_len = 0;
          state_q = PS_NMEA_TYPE;
        end else if (b == UBX_SYNC_A) begin
          state_q = PS_UBX_SYNC2;
        end
      end
      PS_NMEA_TYPE, PS_NMEA_DATA: begin
        if (b == CH_DOLLAR) begin
          sent_xor = '0;
          body_len = 0;
          state_q = PS_NMEA_TYPE;
        end else if (b == CH_STAR) begin
          state_q = PS_NMEA_CK1;
        end else begin
          sent_xor ^= b;
          if (body_len < SENTENCE_CAPACITY_DEF) begin
            if (body_len < 5) head_q[body_len] = b;
            body_len++;
          end
          if (b == CH_COMMA) state_q = PS_NMEA_DATA;
        end
      end
      PS_NMEA_CK1: begin
        ck_high = hex_value(b) << 4;
        state_q = PS_NMEA_CK2;
      end
      PS_NMEA_CK2: begin
        // 9-bit compare: a digit sum above 255 never matches
        given = {1'b0, ck_high} + {1'b0, hex_value(b)};
        emit = 1'b1;
        if (given == {1'b0, sent_xor}) begin
          nmea_ok_cnt++;
          ev.event_kind = EV_NMEA_GOOD;
          ev.sentence_code = sentence_kind();
        end else begin
          nmea_bad_cnt++;
          ev.event_kind = EV_NMEA_BAD;
        end
        state_q = PS_IDLE;
      end
      PS_UBX_SYNC2: state_q = (b == UBX_SYNC_B) ? PS_UBX_CLASS : PS_IDLE;
      PS_UBX_CLASS: begin
        ubx_class = b;
        fl_a = b;
        fl_b = b;
        state_q = PS_UBX_ID;
      end
      PS_UBX_ID: begin
        ubx_id = b;
        fl_a += b;
        fl_b += fl_a;
        state_q = PS_UBX_LEN1;
      end
      PS_UBX_LEN1: begin
        ubx_len = {8'h00, b};
        fl_a += b;
        fl_b += fl_a;
        state_q = PS_UBX_LEN2;
      end
      PS_UBX_LEN2: begin
        ubx_len[15:8] = b;
        fl_a += b;
        fl_b += fl_a;
        pay_idx = '0;
        rec_pos = '0;
        hdr_ok = 1'b0;
        if (ubx_class == CLASS_NAV) begin
          case (ubx_id)
            ID_PVT:   hdr_ok = (ubx_len == pvt_len_q);
            ID_HPPOS: hdr_ok = (ubx_len == hp_len_q);
            ID_DOP:   hdr_ok = (ubx_len == DOP_LEN);
            ID_SAT:   hdr_ok = 1'b1;
            default:  hdr_ok = 1'b0;
          endcase
        end
        if (!hdr_ok) begin
          state_q = PS_IDLE;
        end else begin
          if (ubx_id == ID_SAT) begin
            sig_max = '0;
            sat_used = '0;
          end
          state_q = (ubx_len != 0) ? PS_UBX_PAYLOAD : PS_UBX_CKA;
        end
      end
      PS_UBX_PAYLOAD: begin
        fl_a += b;
        fl_b += fl_a;
        // satellite records of 12 bytes follow an 8 byte head
        if (ubx_class == CLASS_NAV && ubx_id == ID_SAT && pay_idx >= SAT_HEAD_LEN) begin
          if (rec_pos == SAT_SIG_POS) begin
            if (b > sig_max) sig_max = b;
          end else if (rec_pos == SAT_FLAG_POS) begin
            if ((b & SAT_USED_MASK) != 0 && sat_used != 8'hFF) sat_used++;
          end
          rec_pos = (rec_pos >= SAT_REC_LAST) ? 4'd0 : rec_pos + 4'd1;
        end
        pay_idx++;
        if (pay_idx >= ubx_len) state_q = PS_UBX_CKA;
      end
      PS_UBX_CKA: state_q = (b == fl_a) ? PS_UBX_CKB : PS_IDLE;
      PS_UBX_CKB: begin
        state_q = PS_IDLE;
        if (b == fl_b) begin
          ubx_ok_cnt++;
          emit = 1'b1;
          ev.event_kind = EV_UBX_GOOD;
          ev.frame_id = ubx_id;
          ev.payload_length = ubx_len;
          if (ubx_id == ID_SAT) begin
            ev.best_signal = sig_max;
            ev.used_satellites = sat_used;
          end
        end
      end
      default: state_q = PS_IDLE;
    endcase
    if (emit) begin
      ev.nmea_good_total = nmea_ok_cnt;
      ev.nmea_bad_total = nmea_bad_cnt;
      ev.ubx_good_total = ubx_ok_cnt;
      expected_events.push_back(ev);
    end
  endtask

  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_events.size() == 0) begin
        $display("%0t: unexpected event, expected none, actual kind %0h data %h",
                 $time, m_tuser, m_tdata);
        errors++;
      end else begin
        want = expected_events.pop_front();
        report_field("event_kind", want.event_kind, m_tuser);
        report_field("sentence_code", want.sentence_code, m_tdata[1:0]);
        report_field("frame_id", want.frame_id, m_tdata[9:2]);
        report_field("payload_length", want.payload_length, m_tdata[25:10]);
        report_field("best_signal", want.best_signal, m_tdata[33:26]);
        report_field("used_satellites", want.used_satellites, m_tdata[41:34]);
        report_field("nmea_good_total", want.nmea_good_total, m_tdata[73:42]);
        report_field("nmea_bad_total", want.nmea_bad_total, m_tdata[105:74]);
        report_field("ubx_good_total", want.ubx_good_total, m_tdata[137:106]);
      end
    end
  end

  always @(posedge clk) m_tready <= !sink_stalls || ($urandom_range(99) >= 37);

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_byte(input logic [7:0] b);
    if (src_gaps && $urandom_range(99) < 37) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    do @(posedge clk); while (!s_tready);
    parse_byte(b);
    bytes_sent++;
  endtask

  // wait until every event is out and the pipeline has gone quiet
  task automatic drain();
    s_tvalid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_PVT_LEN) pvt_len_q = val;
    else hp_len_q = val;
  endtask

  task automatic set_lengths(input logic [15:0] pvt, input logic [15:0] hp);
    drain();
    write_reg(CFG_PVT_LEN, pvt);
    write_reg(CFG_HP_LEN, hp);
  endtask

  function automatic byte_q_t text_bytes(string t);
    byte_q_t q;
    for (int i = 0; i < t.len(); i++) q.push_back(t[i]);
    return q;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n, bit lower);
    if (n < 10) return 8'h30 + n;
    return (lower ? 8'h61 : 8'h41) + n - 8'd10;
  endfunction

  function automatic logic [7:0] body_byte();
    logic [7:0] b;
    do b = $urandom_range(255); while (b == CH_DOLLAR || b == CH_STAR);
    return b;
  endfunction

  task automatic send_sentence(input byte_q_t body, input ck_mode_t ck);
    logic [7:0] x;
    logic [7:0] hi;
    logic [7:0] lo;
    logic [3:0] flip;
    x = '0;
    foreach (body[i]) x ^= body[i];
    hi = hex_char(x[7:4], ck == CK_LOWER);
    lo = hex_char(x[3:0], ck == CK_LOWER);
    flip = $urandom_range(1, 15);
    case (ck)
      CK_RANDOM: begin
        hi = $urandom_range(255);
        lo = $urandom_range(255);
      end
      CK_BAD_FIRST: hi = hex_char(x[7:4] ^ flip, 1'b0);
      CK_BAD_SECOND: lo = hex_char(x[3:0] ^ flip, 1'b0);
      default: ;
    endcase
    push_byte(CH_DOLLAR);
    foreach (body[i]) push_byte(body[i]);
    push_byte(CH_STAR);
    push_byte(hi);
    push_byte(lo);
  endtask

  // with_tail clear leaves off the checksum pair, for headers that get rejected
  task automatic send_ubx(input logic [7:0] cls, input logic [7:0] id,
                          input logic [15:0] len, input int n_pay, input bit force_used,
                          input ck_mode_t ck, input bit with_tail);
    byte_q_t fr;
    logic [7:0] v;
    logic [7:0] a;
    logic [7:0] s;
    logic [7:0] flip;
    int i;
    fr = '{cls, id, len[7:0], len[15:8]};
    for (i = 0; i < n_pay; i++) begin
      v = $urandom_range(255);
      if (force_used && i >= SAT_HEAD_LEN && (i - SAT_HEAD_LEN) % 12 == SAT_FLAG_POS)
        v |= SAT_USED_MASK;
      fr.push_back(v);
    end
    a = '0;
    s = '0;
    foreach (fr[k]) begin
      a += fr[k];
      s += a;
    end
    flip = $urandom_range(1, 255);
    if (ck == CK_BAD_FIRST) a ^= flip;
    if (ck == CK_BAD_SECOND) s ^= flip;
    push_byte(UBX_SYNC_A);
    push_byte(UBX_SYNC_B);
    foreach (fr[k]) push_byte(fr[k]);
    if (with_tail) begin
      push_byte(a);
      push_byte(s);
    end
  endtask

  // a required length too long to send is replaced by a mismatching header
  task automatic nav_frame(input logic [7:0] id, input logic [15:0] len, input ck_mode_t ck);
    if (len <= 200) send_ubx(CLASS_NAV, id, len, len, 1'b0, ck, 1'b1);
    else send_ubx(CLASS_NAV, id, $urandom_range(0, 200), 0, 1'b0, CK_GOOD, 1'b0);
  endtask

  task automatic random_sentence();
    byte_q_t body;
    ck_mode_t ck;
    string talkers;
    string field_chars;
    int r;
    talkers = "PNABLX";
    field_chars = "0123456789.,NSEWM";
    r = $urandom_range(99);
    if (r < 60) begin
      body.push_back("G");
      body.push_back(talkers[$urandom_range(5)]);
      case ($urandom_range(3))
        0: body = {body, text_bytes("GGA")};
        1: body = {body, text_bytes("RMC")};
        2: body = {body, text_bytes("GSV")};
        default: repeat (3) body.push_back(8'h41 + $urandom_range(25));
      endcase
      if ($urandom_range(3) != 0) begin
        body.push_back(CH_COMMA);
        repeat ($urandom_range(0, 16))
          body.push_back(field_chars[$urandom_range(field_chars.len() - 1)]);
      end
    end else if (r < 95) begin
      repeat ($urandom_range(0, 8)) body.push_back(body_byte());
    end else begin
      // long bodies, some of them past the body counter limit
      repeat ($urandom_range(120, 150))
        body.push_back(field_chars[$urandom_range(field_chars.len() - 1)]);
    end
    // an aborted sentence just ahead of this one
    if ($urandom_range(19) == 0) begin
      push_byte(CH_DOLLAR);
      repeat ($urandom_range(0, 6)) push_byte(body_byte());
    end
    r = $urandom_range(99);
    if (r < 74) ck = CK_GOOD;
    else if (r < 82) ck = CK_LOWER;
    else if (r < 90) ck = CK_RANDOM;
    else if (r < 95) ck = CK_BAD_FIRST;
    else ck = CK_BAD_SECOND;
    send_sentence(body, ck);
  endtask

  task automatic random_ubx();
    ck_mode_t ck;
    logic [7:0] cls;
    logic [7:0] id;
    logic [15:0] len;
    logic [15:0] flip;
    int r;
    int n;
    ck = CK_GOOD;
    if ($urandom_range(9) == 0) ck = $urandom_range(1) ? CK_BAD_FIRST : CK_BAD_SECOND;
    r = $urandom_range(99);
    if (r < 18) begin
      nav_frame(ID_PVT, pvt_len_q, ck);
    end else if (r < 34) begin
      nav_frame(ID_HPPOS, hp_len_q, ck);
    end else if (r < 50) begin
      nav_frame(ID_DOP, DOP_LEN, ck);
    end else if (r < 80) begin
      n = ($urandom_range(4) == 0) ? $urandom_range(0, 7) : 8 + 12 * $urandom_range(0, 4);
      send_ubx(CLASS_NAV, ID_SAT, n, n, $urandom_range(1), ck, 1'b1);
    end else if (r < 87) begin
      cls = $urandom_range(255);
      if (cls == CLASS_NAV) cls = ~cls;
      send_ubx(cls, $urandom_range(255), $urandom_range(65535), 0, 1'b0, CK_GOOD, 1'b0);
    end else if (r < 93) begin
      id = $urandom_range(255);
      if (id inside {ID_PVT, ID_HPPOS, ID_DOP, ID_SAT}) id = ~id;
      send_ubx(CLASS_NAV, id, $urandom_range(65535), 0, 1'b0, CK_GOOD, 1'b0);
    end else begin
      flip = $urandom_range(1, 65535);
      case ($urandom_range(2))
        0: begin id = ID_PVT; len = pvt_len_q ^ flip; end
        1: begin id = ID_HPPOS; len = hp_len_q ^ flip; end
        default: begin id = ID_DOP; len = DOP_LEN ^ flip; end
      endcase
      send_ubx(CLASS_NAV, id, len, 0, 1'b0, CK_GOOD, 1'b0);
    end
  endtask

  task automatic random_mix(input int unsigned n_bytes);
    int unsigned stop_at;
    logic [7:0] b;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      case ($urandom_range(9))
        0, 1, 2, 3: random_sentence();
        4, 5, 6, 7, 8: random_ubx();
        default: begin
          // line noise or a lone first sync byte
          if ($urandom_range(1)) begin
            b = $urandom_range(255);
            if (b == UBX_SYNC_B) b = ~b;
            push_byte(UBX_SYNC_A);
            push_byte(b);
          end else begin
            repeat ($urandom_range(1, 3)) push_byte(body_byte());
          end
        end
      endcase
    end
  endtask

  task automatic test_directed();
    send_sentence(text_bytes("GPGGA"), CK_GOOD);
    send_sentence(text_bytes("GLRMC,A"), CK_GOOD);
    send_sentence(text_bytes("GXGGA"), CK_GOOD);
    send_sentence(text_bytes("GP"), CK_BAD_SECOND);
    // dollar inside a body restarts the sentence
    push_byte(CH_DOLLAR);
    push_byte("G");
    push_byte("B");
    send_sentence(text_bytes("GBGGA"), CK_LOWER);
    // checksum digits take any byte; this pair sums past 255
    push_byte(CH_DOLLAR);
    push_byte(CH_STAR);
    push_byte(CH_DOLLAR);
    push_byte(8'hFF);
    push_byte(CH_DOLLAR);
    push_byte(CH_STAR);
    push_byte("0");
    push_byte("0");
    send_ubx(CLASS_NAV, ID_SAT, 16'd0, 0, 1'b0, CK_GOOD, 1'b1);
    send_ubx(CLASS_NAV, ID_SAT, 16'd20, 20, 1'b1, CK_GOOD, 1'b1);
    send_ubx(CLASS_NAV, ID_DOP, DOP_LEN, DOP_LEN, 1'b0, CK_GOOD, 1'b1);
    send_ubx(~CLASS_NAV, ID_DOP, DOP_LEN, 0, 1'b0, CK_GOOD, 1'b0);
    send_ubx(CLASS_NAV, ID_DOP, DOP_LEN, DOP_LEN, 1'b0, CK_BAD_FIRST, 1'b1);
    send_ubx(CLASS_NAV, ID_SAT, 16'd8, 8, 1'b0, CK_BAD_SECOND, 1'b1);
  endtask

  task automatic test_reset_lengths();
    random_mix(200);
  endtask

  task automatic test_zero_and_max_lengths();
    set_lengths(16'd0, 16'hFFFF);
    random_mix(200);
  endtask

  task automatic test_no_stalls();
    set_lengths($urandom_range(1, 60), 16'd0);
    src_gaps = 1'b0;
    sink_stalls = 1'b0;
    random_mix(200);
    src_gaps = 1'b1;
    sink_stalls = 1'b1;
  endtask

  task automatic test_saturation();
    set_lengths(16'hFFFF, $urandom_range(1, 60));
    // a long satellite frame with every record flagged used
    send_ubx(CLASS_NAV, ID_SAT, 16'd248, 248, 1'b1, CK_GOOD, 1'b1);
    send_sentence({text_bytes("GPRMC,"), text_bytes({30{"12345"}})}, CK_GOOD);
  endtask

  task automatic test_restored_lengths();
    set_lengths(PVT_LEN_RESET, HP_LEN_RESET);
    random_mix(200);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_reset_lengths();
    test_zero_and_max_lengths();
    test_no_stalls();
    test_saturation();
    test_restored_lengths();
    drain();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
